[src/vnorm_pkg.sv]
// vnorm_pkg: payload and pipeline stage types plus step functions for vector_normalize
// no dependencies; imported by vector_normalize, vnorm_checker and tb_top
package vnorm_pkg;

    localparam int COMP_W     = 24;
    localparam int UNIT_W     = 16;
    localparam int UNIT_FRAC  = 14;
    localparam int SUM_W      = 48;
    localparam int SQRT_STEPS = 24;
    localparam int SQ_REM_W   = 27;
    localparam int DIV_STEPS  = 15;
    localparam int DV_REM_W   = 25;
    localparam int NUM_W      = 39;
    localparam int LANES      = 3;
    localparam logic [DIV_STEPS-1:0] UNIT_ONE = 15'd16384;

    typedef struct packed {
        logic signed [COMP_W-1:0] x_in;
        logic signed [COMP_W-1:0] y_in;
        logic signed [COMP_W-1:0] z_in;
    } in_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] x_unit;
        logic signed [UNIT_W-1:0] y_unit;
        logic signed [UNIT_W-1:0] z_unit;
        logic        [COMP_W-1:0] magnitude;
        logic                     zero_vector;
    } out_t;

    // square stage: magnitudes of components and their squares
    typedef struct packed {
        logic [LANES-1:0][COMP_W-1:0]   a;
        logic [LANES-1:0]               neg;
        logic [LANES-1:0][UNIT_W-1:0]   raw;
        logic [LANES-1:0][2*COMP_W-1:0] sq;
    } sqr_t;

    // square root stage: one result bit per stage
    typedef struct packed {
        logic [SQ_REM_W-1:0]          rem;
        logic [COMP_W-1:0]            root;
        logic [SUM_W-1:0]             n;
        logic [LANES-1:0][COMP_W-1:0] a;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][UNIT_W-1:0] raw;
    } sqst_t;

    // divide stage: one quotient bit per stage in each lane
    typedef struct packed {
        logic [COMP_W-1:0]               mag;
        logic [LANES-1:0][DV_REM_W-1:0]  rem;
        logic [LANES-1:0][DIV_STEPS-1:0] nlo;
        logic [LANES-1:0][DIV_STEPS-1:0] q;
        logic [LANES-1:0]                neg;
        logic [LANES-1:0][UNIT_W-1:0]    raw;
    } dvst_t;

    function automatic sqst_t sqrt_step(sqst_t s);
        sqst_t                r;
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        r      = s;
        rem_sh = {s.rem[SQ_REM_W-3:0], s.n[SUM_W-1:SUM_W-2]};
        trial  = {1'b0, s.root, 2'b01};
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {s.root[COMP_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {s.root[COMP_W-2:0], 1'b0};
        end
        r.n = {s.n[SUM_W-3:0], 2'b00};
        return r;
    endfunction

    function automatic dvst_t div_init(sqst_t s);
        dvst_t            r;
        logic [NUM_W-1:0] num;
        r.mag = s.root;
        r.neg = s.neg;
        r.raw = s.raw;
        for (int i = 0; i < LANES; i++)
        begin
            num = {1'b0, s.a[i], {UNIT_FRAC{1'b0}}}
                + {{(NUM_W-COMP_W+1){1'b0}}, s.root[COMP_W-1:1]};
            r.rem[i] = {2'b00, num[NUM_W-2:DIV_STEPS]};
            r.nlo[i] = num[DIV_STEPS-1:0];
            r.q[i]   = '0;
        end
        return r;
    endfunction

    function automatic dvst_t div_step(dvst_t s);
        dvst_t               r;
        logic [DV_REM_W-1:0] rem_sh;
        r = s;
        for (int i = 0; i < LANES; i++)
        begin
            rem_sh = {s.rem[i][DV_REM_W-2:0], s.nlo[i][DIV_STEPS-1]};
            if (rem_sh >= {1'b0, s.mag})
            begin
                r.rem[i] = rem_sh - {1'b0, s.mag};
                r.q[i]   = {s.q[i][DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                r.rem[i] = rem_sh;
                r.q[i]   = {s.q[i][DIV_STEPS-2:0], 1'b0};
            end
            r.nlo[i] = {s.nlo[i][DIV_STEPS-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[src/vector_normalize.sv]
// vector_normalize: pipelined 2d/3d vector normalizer, top level
// depends on vnorm_pkg for payload types and stage step functions

// Takes one vector per cycle and gives one result per cycle while the output
// is not stalled, through one square stage, one sum stage, 24 square root
// stages (one root bit each), one divider setup stage, 15 divider stages (one
// quotient bit each, three lanes) and the output register. The whole pipeline
// advances together whenever the output register is empty or being taken, so
// a stall at the output holds every stage. cfg_data[0] sets three_dims (reset
// 1); write it only while the pipeline is empty.
module vector_normalize
    import vnorm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);

    logic  three_dims_reg;
    logic  adv;

    logic  sqr_v_reg;
    sqr_t  sqr_reg;
    logic  [SQRT_STEPS:0] sq_v_reg;
    sqst_t sq_reg [SQRT_STEPS+1];
    logic  [DIV_STEPS:0] dv_v_reg;
    dvst_t dv_reg [DIV_STEPS+1];
    logic  out_v_reg;
    out_t  out_reg;
    out_t  out_next;
    sqr_t  sqr_next;
    sqst_t sq0_next;

    assign adv       = !out_v_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            three_dims_reg <= 1'b1;
        else if (cfg_valid)
            three_dims_reg <= cfg_data;
    end

    // component magnitudes and squares
    always_comb
    begin
        logic signed [COMP_W-1:0] c [LANES];
        c[0] = in_data.x_in;
        c[1] = in_data.y_in;
        c[2] = three_dims_reg ? in_data.z_in : '0;
        for (int i = 0; i < LANES; i++)
        begin
            sqr_next.neg[i] = c[i][COMP_W-1];
            sqr_next.a[i]   = c[i][COMP_W-1] ? COMP_W'(-c[i]) : COMP_W'(c[i]);
            sqr_next.raw[i] = c[i][UNIT_W-1:0];
            sqr_next.sq[i]  = sqr_next.a[i] * sqr_next.a[i];
        end
    end

    // sum of squares into the root pipeline
    always_comb
    begin
        sq0_next.rem  = '0;
        sq0_next.root = '0;
        sq0_next.n    = sqr_reg.sq[0] + sqr_reg.sq[1] + sqr_reg.sq[2];
        sq0_next.a    = sqr_reg.a;
        sq0_next.neg  = sqr_reg.neg;
        sq0_next.raw  = sqr_reg.raw;
    end

    // sign, clamp and zero vector handling
    always_comb
    begin
        logic [DIV_STEPS-1:0] q;
        logic [UNIT_W-1:0]    u [LANES];
        for (int i = 0; i < LANES; i++)
        begin
            q    = (dv_reg[DIV_STEPS].q[i] > UNIT_ONE) ? UNIT_ONE : dv_reg[DIV_STEPS].q[i];
            u[i] = dv_reg[DIV_STEPS].neg[i] ? UNIT_W'(-{1'b0, q}) : {1'b0, q};
        end
        out_next.magnitude   = dv_reg[DIV_STEPS].mag;
        out_next.zero_vector = (dv_reg[DIV_STEPS].mag == '0);
        if (out_next.zero_vector)
        begin
            out_next.x_unit = dv_reg[DIV_STEPS].raw[0];
            out_next.y_unit = dv_reg[DIV_STEPS].raw[1];
            out_next.z_unit = dv_reg[DIV_STEPS].raw[2];
        end
        else
        begin
            out_next.x_unit = u[0];
            out_next.y_unit = u[1];
            out_next.z_unit = u[2];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqr_v_reg <= 1'b0;
            sq_v_reg  <= '0;
            dv_v_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            sqr_v_reg <= in_valid;
            sq_v_reg  <= {sq_v_reg[SQRT_STEPS-1:0], sqr_v_reg};
            dv_v_reg  <= {dv_v_reg[DIV_STEPS-1:0], sq_v_reg[SQRT_STEPS]};
            out_v_reg <= dv_v_reg[DIV_STEPS];
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqr_reg   <= sqr_next;
            sq_reg[0] <= sq0_next;
            for (int k = 0; k < SQRT_STEPS; k++)
                sq_reg[k+1] <= sqrt_step(sq_reg[k]);
            dv_reg[0] <= div_init(sq_reg[SQRT_STEPS]);
            for (int k = 0; k < DIV_STEPS; k++)
                dv_reg[k+1] <= div_step(dv_reg[k]);
            out_reg <= out_next;
        end
    end

endmodule

[src/vnorm_checker.sv]
// vnorm_checker: port-level assertions for vector_normalize, with its bind
// depends on vnorm_pkg and the vector_normalize ports
module vnorm_checker
    import vnorm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data,
    input logic cfg_ready
);

    // a stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // a zero vector has zero magnitude and zero units
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_vector |-> out_data.magnitude == '0
            && out_data.x_unit == '0 && out_data.y_unit == '0 && out_data.z_unit == '0)
        else $error("zero vector result not clean");

    // a normalized result has a nonzero length
    a_mag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.zero_vector |-> out_data.magnitude != '0)
        else $error("zero magnitude without flag");

    // unit components stay within one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.x_unit <= 16'sd16384 && out_data.x_unit >= -16'sd16384
            && out_data.y_unit <= 16'sd16384 && out_data.y_unit >= -16'sd16384
            && out_data.z_unit <= 16'sd16384 && out_data.z_unit >= -16'sd16384)
        else $error("unit component out of range");

    // input is taken whenever the output side is free
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready && cfg_ready)
        else $error("pipeline stalled without output backpressure");

endmodule

bind vector_normalize vnorm_checker u_vnorm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench for vector_normalize
// depends on vnorm_pkg and vector_normalize; drives vectors, predicts unit results

module tb_top;
    import vnorm_pkg::*;

    localparam int LATENCY   = 43;
    localparam int MAX_CYCLE = 1500000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;

    // stimulus and expectation stores
    in_t  pending_vecs[$];
    out_t expected_units[$];
    logic mode_3d;
    int   errors;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;

    vector_normalize u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // integer square root, rounded down
    function automatic logic [47:0] root_floor(logic [47:0] n);
        logic [47:0] root;
        logic [47:0] bitv;
        root = '0;
        bitv = 48'h1 << 46;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // component over magnitude as q2.14, rounded half away from zero
    function automatic logic signed [15:0] unit_q14(logic signed [23:0] c,
                                                    logic [23:0] mag);
        logic [63:0] a;
        logic [63:0] q;
        a = (c < 0) ? 64'(-65'(c)) : 64'(c);
        q = ((a << 14) + (mag >> 1)) / mag;
        if (q > 16384)
            q = 16384;
        if (c < 0)
            q = -q;
        return q[15:0];
    endfunction

    function automatic out_t predict_unit(in_t v, logic three);
        out_t r;
        logic signed [23:0] z;
        logic signed [47:0] xw;
        logic signed [47:0] yw;
        logic signed [47:0] zw;
        logic [47:0] sum;
        logic [47:0] mag;
        z   = three ? v.z_in : 24'sd0;
        xw  = v.x_in;
        yw  = v.y_in;
        zw  = z;
        sum = xw * xw + yw * yw + zw * zw;
        mag = root_floor(sum);
        if (mag == 0)
        begin
            r.x_unit      = v.x_in[15:0];
            r.y_unit      = v.y_in[15:0];
            r.z_unit      = z[15:0];
            r.magnitude   = '0;
            r.zero_vector = 1'b1;
        end
        else
        begin
            r.x_unit      = unit_q14(v.x_in, mag[23:0]);
            r.y_unit      = unit_q14(v.y_in, mag[23:0]);
            r.z_unit      = three ? unit_q14(z, mag[23:0]) : 16'sd0;
            r.magnitude   = mag[23:0];
            r.zero_vector = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic logic signed [23:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'(int'($urandom_range(0, 16)) - 8);
            3: return 24'(int'($urandom_range(0, 8192)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    // driver: sender side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_vecs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                expected_units.push_back(predict_unit(pending_vecs[0], mode_3d));
                in_data  <= pending_vecs.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern, with a long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_units.size() == 0)
            begin
                $display("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                out_t e;
                e = expected_units.pop_front();
                if (out_data.x_unit !== e.x_unit)
                    report_mismatch("x_unit", out_data.x_unit, e.x_unit);
                if (out_data.y_unit !== e.y_unit)
                    report_mismatch("y_unit", out_data.y_unit, e.y_unit);
                if (out_data.z_unit !== e.z_unit)
                    report_mismatch("z_unit", out_data.z_unit, e.z_unit);
                if (out_data.magnitude !== e.magnitude)
                    report_mismatch("magnitude", out_data.magnitude, e.magnitude);
                if (out_data.zero_vector !== e.zero_vector)
                    report_mismatch("zero_vector", out_data.zero_vector, e.zero_vector);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_vecs.size() > 0 || in_valid || expected_units.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_mode(logic three);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= three;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_3d = three;
    endtask

    task automatic push_vec(logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z);
        in_t v;
        v.x_in = x;
        v.y_in = y;
        v.z_in = z;
        pending_vecs.push_back(v);
    endtask

    task automatic run_phase(int n, int idle, int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            push_vec(rand_comp(), rand_comp(), rand_comp());
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        errors         = 0;
        cycle_count    = 0;
        hold_off       = 0;
        mode_3d        = 1'b1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero vector, both modes
        write_mode(1'b1);
        push_vec(0, 0, 0);
        push_vec(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        push_vec(24'sh800000, 24'sh800000, 24'sh800000);
        push_vec(24'sh800000, 0, 0);
        push_vec(0, 24'sh7FFFFF, 0);
        push_vec(0, 0, -1);
        push_vec(1, 1, 1);
        push_vec(-1, 1, -1);
        push_vec(4096, 0, 0);
        push_vec(3, 4, 0);
        push_vec(0, 0, 24'sh800000);
        wait_drained();
        write_mode(1'b0);
        push_vec(0, 0, 24'sh7FFFFF);
        push_vec(0, 0, 0);
        push_vec(24'sh7FFFFF, 24'sh800000, 5);
        push_vec(-3, 4, -1);
        push_vec(1, 0, 24'sh800000);
        push_vec(24'sh800000, 24'sh800000, 0);
        wait_drained();

        // random phases across both settings and idling mixes
        run_phase(200, 0, 0);
        repeat (LATENCY) @(posedge clk);
        write_mode(1'b1);
        run_phase(150, 81, 0);
        run_phase(150, 0, 81);
        repeat (LATENCY) @(posedge clk);
        write_mode(1'b0);
        run_phase(150, 25, 25);
        repeat (LATENCY) @(posedge clk);
        write_mode(1'b1);
        // long receiver hold-off while vectors keep coming
        hold_off = 200;
        run_phase(150, 0, 0);
        run_phase(130, 25, 25);

        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && expected_units.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
